### sv/hsg_pkg.sv
// Package: shared types and constants for the haptic spring and grip force core
`timescale 1ns / 1ps
package hsg_pkg;

  localparam logic [31:0] GRIP_OFFSET = 32'd878453;
  localparam logic signed [31:0] COEF_B0 = 32'sd58948;
  localparam logic signed [31:0] COEF_B1 = 32'sd176845;
  localparam logic signed [31:0] COEF_A1 = 32'sd737875381;
  localparam logic signed [31:0] COEF_A2 = -32'sd678658520;
  localparam logic signed [31:0] COEF_A3 = 32'sd208735411;
  localparam logic [7:0] HOLD_TASK = 8'd10;
  localparam logic [3:0] PHASE_GRASP_A = 4'd2;
  localparam logic [3:0] PHASE_GRASP_B = 4'd3;

  localparam logic [2:0] REG_BASE_X = 3'd0;
  localparam logic [2:0] REG_BASE_Y = 3'd1;
  localparam logic [2:0] REG_BASE_Z = 3'd2;
  localparam logic [2:0] REG_GAIN   = 3'd3;
  localparam logic [2:0] REG_CAP    = 3'd4;
  localparam logic [2:0] REG_SCALE  = 3'd5;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_KSRCH,
    ST_FORCE,
    ST_GRIP,
    ST_DIFF,
    ST_FILT,
    ST_FINISH,
    ST_OUT
  } state_t;

  // serial multiplier control
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

endpackage

### sv/hsg_serial_mul.sv
// Shift-add multiplier: unsigned 64x64 -> 128, one multiplier bit per cycle
`timescale 1ns / 1ps
module hsg_serial_mul (
  input  logic              clk,
  input  logic              rst,
  input  hsg_pkg::mul_req_t req,
  output logic              busy,
  output logic [127:0]      prod
);

  logic [63:0]  mplier;
  logic [127:0] mcand;
  logic [6:0]   cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mplier <= req.b;
      mcand  <= {64'd0, req.a};
      prod   <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mplier <= mplier >> 1;
      mcand  <= mcand << 1;
    end
  end

endmodule

### sv/haptic_spring_and_grip_force_core.sv
// Top level: spring stiffness, spring force and grip filter over a shared serial multiplier
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   input   | in_valid, in_stall, pos_*, grip_angle, ...     | in
//   output  | out_valid, out_stall, force_*, grip_force, ... | out
//   config  | psel, penable, pwrite, paddr, pwdata, prdata   | APB
//
// The stiffness search takes at most ten steps, none when the stiffness is forced to
// zero; each step is one serial multiply.
// rst clears control state and the priming flag and resets the configuration registers.
// The result is held in output registers until taken; a new item is taken
// once the previous result has left and the state has returned to idle.
`timescale 1ns / 1ps
module haptic_spring_and_grip_force_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] grip_angle,
  input  logic signed [31:0] slave_grasp,
  input  logic [3:0]         grasp_phase,
  input  logic [7:0]         task_state,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] force_z,
  output logic [30:0]        grip_force,
  output logic [9:0]         stiffness,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration
  logic [31:0] base_x, base_y, base_z, grip_scale;
  logic [7:0]  stiffness_gain;
  logic [9:0]  stiffness_cap;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x         <= '0;
      base_y         <= '0;
      base_z         <= '0;
      stiffness_gain <= 8'd4;
      stiffness_cap  <= 10'd200;
      grip_scale     <= 32'd16777216;
    end else if (cfg_wr) begin
      case (reg_idx)
        hsg_pkg::REG_BASE_X: base_x <= pwdata;
        hsg_pkg::REG_BASE_Y: base_y <= pwdata;
        hsg_pkg::REG_BASE_Z: base_z <= pwdata;
        hsg_pkg::REG_GAIN:   stiffness_gain <= pwdata[7:0];
        hsg_pkg::REG_CAP:    stiffness_cap <= pwdata[9:0];
        hsg_pkg::REG_SCALE:  grip_scale <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hsg_pkg::REG_BASE_X: prdata = base_x;
      hsg_pkg::REG_BASE_Y: prdata = base_y;
      hsg_pkg::REG_BASE_Z: prdata = base_z;
      hsg_pkg::REG_GAIN:   prdata = {24'd0, stiffness_gain};
      hsg_pkg::REG_CAP:    prdata = {22'd0, stiffness_cap};
      hsg_pkg::REG_SCALE:  prdata = grip_scale;
      default:             prdata = '0;
    endcase
  end

  // item registers
  logic signed [32:0] d [3];
  logic signed [31:0] grasp_in;
  logic               k_off;

  // filter state
  logic signed [31:0] xh [3];
  logic signed [31:0] yh [3];
  logic               primed;

  // work registers
  hsg_pkg::state_t state, state_next;
  logic [4:0]   step;
  logic         issued;
  logic [65:0]  ssum;
  logic         s_ovf;
  logic [63:0]  gsq;
  logic [10:0]  k_lo, k_hi;
  logic [9:0]   kval;
  logic signed [31:0] diff;
  logic signed [33:0] tval;
  logic signed [69:0] acc;

  // multiplier
  hsg_pkg::mul_req_t mreq;
  logic         mbusy;
  logic [127:0] mprod;

  hsg_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .busy(mbusy),
    .prod(mprod)
  );

  logic mdone;
  assign mdone = issued && !mbusy && !mreq.start;

  assign in_stall = (state != hsg_pkg::ST_IDLE);

  // operand selection
  logic [32:0] dmag;
  logic [10:0] kmid;
  logic signed [31:0] fcoef;
  logic signed [31:0] fsamp;
  logic [63:0] fmag_c, fmag_s;

  always_comb begin
    dmag = d[step[1:0]][32] ? 33'(-d[step[1:0]]) : d[step[1:0]];
    kmid = 11'((k_lo + k_hi + 11'd1) >> 1);
    case (step[2:0])
      3'd0: begin fcoef = hsg_pkg::COEF_B0; fsamp = diff;  end
      3'd1: begin fcoef = hsg_pkg::COEF_B1; fsamp = xh[0]; end
      3'd2: begin fcoef = hsg_pkg::COEF_B1; fsamp = xh[1]; end
      3'd3: begin fcoef = hsg_pkg::COEF_B0; fsamp = xh[2]; end
      3'd4: begin fcoef = hsg_pkg::COEF_A1; fsamp = yh[0]; end
      3'd5: begin fcoef = hsg_pkg::COEF_A2; fsamp = yh[1]; end
      default: begin fcoef = hsg_pkg::COEF_A3; fsamp = yh[2]; end
    endcase
    fmag_c = fcoef[31] ? -64'(fcoef) : 64'(fcoef);
    fmag_s = fsamp[31] ? -64'(fsamp) : 64'(fsamp);
  end

  // next state and multiplier requests
  always_comb begin
    state_next = state;
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;
    case (state)
      hsg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = hsg_pkg::ST_SQ;
        end
      end
      hsg_pkg::ST_SQ: begin
        if (!issued) begin
          mreq.start = 1'b1;
          mreq.a = 64'(dmag);
          mreq.b = 64'(dmag);
        end else if (mdone && step == 5'd2) begin
          state_next = hsg_pkg::ST_KSRCH;
        end
      end
      hsg_pkg::ST_KSRCH: begin
        if (k_lo >= k_hi) begin
          state_next = hsg_pkg::ST_FORCE;
        end else if (!issued) begin
          mreq.start = 1'b1;
          mreq.a = 64'(22'(kmid) * 22'(kmid));
          mreq.b = ssum[63:0];
        end
      end
      hsg_pkg::ST_FORCE: begin
        if (!issued) begin
          mreq.start = 1'b1;
          mreq.a = 64'(kval);
          mreq.b = 64'(dmag);
        end else if (mdone && step == 5'd2) begin
          state_next = hsg_pkg::ST_GRIP;
        end
      end
      hsg_pkg::ST_GRIP: begin
        if (!issued) begin
          mreq.start = 1'b1;
          mreq.a = tval[33] ? 64'(-tval) : 64'(tval);
          mreq.b = 64'(grip_scale);
        end else if (mdone) begin
          state_next = hsg_pkg::ST_DIFF;
        end
      end
      hsg_pkg::ST_DIFF: begin
        state_next = hsg_pkg::ST_FILT;
      end
      hsg_pkg::ST_FILT: begin
        if (!issued) begin
          mreq.start = 1'b1;
          mreq.a = fmag_c;
          mreq.b = fmag_s;
        end else if (mdone && step == 5'd6) begin
          state_next = hsg_pkg::ST_FINISH;
        end
      end
      hsg_pkg::ST_FINISH: begin
        state_next = hsg_pkg::ST_OUT;
      end
      hsg_pkg::ST_OUT: begin
        if (out_valid && !out_stall) begin
          state_next = hsg_pkg::ST_IDLE;
        end
      end
      default: state_next = hsg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  logic signed [69:0] prod_s;
  logic signed [64:0] grip_s;
  logic signed [65:0] dwide;
  logic signed [69:0] yr;
  logic signed [31:0] ysat;

  always_comb begin
    prod_s = ((fcoef[31] ^ fsamp[31]) ? -70'(mprod[63:0]) : 70'(mprod[63:0]));
    grip_s = 65'(mprod[63:24]) + 65'(mprod[23]);
    if (tval[33]) begin
      grip_s = -grip_s;
    end
    dwide = 66'(grasp_in) - 66'(grip_s);
    yr    = (acc + 70'sd134217728) >>> 28;
    if (yr > 70'sd2147483647) begin
      ysat = 32'h7FFFFFFF;
    end else if (yr < -70'sd2147483648) begin
      ysat = 32'h80000000;
    end else begin
      ysat = 32'(yr);
    end
  end

  logic signed [63:0] fprod;
  logic signed [63:0] fr;
  assign fprod = d[step[1:0]][32] ? 64'(mprod[63:0]) : -64'(mprod[63:0]);
  assign fr    = (fprod + 64'sd128) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      issued    <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
      primed    <= 1'b0;
    end else begin
      if (mreq.start) begin
        issued <= 1'b1;
      end
      case (state)
        hsg_pkg::ST_IDLE: begin
          if (in_valid) begin
            d[0]     <= 33'(pos_x) - 33'(signed'(base_x));
            d[1]     <= 33'(pos_y) - 33'(signed'(base_y));
            d[2]     <= 33'(pos_z) - 33'(signed'(base_z));
            tval     <= 34'(grip_angle) - 34'(hsg_pkg::GRIP_OFFSET);
            grasp_in <= slave_grasp;
            k_off    <= (grasp_phase == hsg_pkg::PHASE_GRASP_A ||
                         grasp_phase == hsg_pkg::PHASE_GRASP_B) &&
                        task_state != hsg_pkg::HOLD_TASK;
            ssum     <= '0;
            s_ovf    <= 1'b0;
            step     <= '0;
            issued   <= 1'b0;
          end
        end
        hsg_pkg::ST_SQ: begin
          if (mdone) begin
            if (dmag[32] || (66'(ssum) + 66'(mprod[63:0])) > 66'hFFFFFFFFFFFFFFFF) begin
              s_ovf <= 1'b1;
            end
            ssum   <= ssum + 66'(mprod[63:0]);
            issued <= 1'b0;
            step   <= step + 5'd1;
            if (step == 5'd2) begin
              gsq  <= 64'(16'(stiffness_gain) * 16'(stiffness_gain)) << 48;
              k_lo <= '0;
              k_hi <= (k_off || s_ovf || dmag[32] ||
                       (66'(ssum) + 66'(mprod[63:0])) > 66'hFFFFFFFFFFFFFFFF) ?
                      11'd0 : 11'(stiffness_cap);
            end
          end
        end
        hsg_pkg::ST_KSRCH: begin
          if (k_lo >= k_hi) begin
            kval   <= 10'(k_lo);
            step   <= '0;
            issued <= 1'b0;
          end else if (mdone) begin
            if (mprod <= 128'(gsq)) begin
              k_lo <= kmid;
            end else begin
              k_hi <= kmid - 11'd1;
            end
            issued <= 1'b0;
          end
        end
        hsg_pkg::ST_FORCE: begin
          if (mdone) begin
            case (step[1:0])
              2'd0: force_x <= 32'(fr);
              2'd1: force_y <= 32'(fr);
              default: force_z <= 32'(fr);
            endcase
            issued <= 1'b0;
            step   <= step + 5'd1;
          end
        end
        hsg_pkg::ST_GRIP: begin
          if (mdone) begin
            issued <= 1'b0;
          end
        end
        hsg_pkg::ST_DIFF: begin
          if (dwide > 66'sd2147483647) begin
            diff <= 32'h7FFFFFFF;
          end else if (dwide < -66'sd2147483648) begin
            diff <= 32'h80000000;
          end else begin
            diff <= 32'(dwide);
          end
          acc  <= '0;
          step <= '0;
        end
        hsg_pkg::ST_FILT: begin
          if (!primed && step == 5'd0 && !issued) begin
            xh[0] <= diff; xh[1] <= diff; xh[2] <= diff;
            yh[0] <= diff; yh[1] <= diff; yh[2] <= diff;
            primed <= 1'b1;
          end
          if (mdone) begin
            acc    <= acc + prod_s;
            issued <= 1'b0;
            step   <= step + 5'd1;
          end
        end
        hsg_pkg::ST_FINISH: begin
          xh[2] <= xh[1]; xh[1] <= xh[0]; xh[0] <= diff;
          yh[2] <= yh[1]; yh[1] <= yh[0]; yh[0] <= ysat;
          grip_force <= (ysat > 32'sd0) ? 31'((33'(ysat) + 33'sd128) >>> 8) : 31'd0;
          stiffness  <= kval;
          out_valid  <= 1'b1;
        end
        hsg_pkg::ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == hsg_pkg::ST_OUT) else $error("result shown outside output state");
  a_stiff_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stiffness <= stiffness_cap || $past(cfg_wr))
    else $error("stiffness above cap");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != hsg_pkg::ST_IDLE |-> in_stall) else $error("item taken while busy");
  a_primed_stays: assert property (@(posedge clk) disable iff (rst)
    $past(primed) && !$past(rst) |-> primed) else $error("filter history lost priming");

endmodule

### tb/tb_haptic_spring_and_grip_force_core.sv
// Testbench: directed and random servo ticks against a spring and grip-filter predictor
`timescale 1ns / 1ps
module tb_haptic_spring_and_grip_force_core;

  localparam longint CYCLE_LIMIT = 8000000;

  typedef struct {
    logic signed [31:0] px, py, pz, angle, grasp;
    logic [3:0]         phase;
    logic [7:0]         task_code;
    int                 known_k;
  } tick_t;

  typedef struct {
    logic signed [31:0] fx, fy, fz;
    logic [30:0]        grip;
    logic [9:0]         k;
  } force_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] pos_x, pos_y, pos_z, grip_angle, slave_grasp;
  logic [3:0] grasp_phase;
  logic [7:0] task_state;
  logic signed [31:0] force_x, force_y, force_z;
  logic [30:0] grip_force;
  logic [9:0] stiffness;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  logic signed [31:0] anchor_x, anchor_y, anchor_z;
  logic [7:0]  gain_reg;
  logic [9:0]  cap_reg;
  logic [31:0] scale_reg;
  longint grip_hist[3];
  longint filt_hist[3];
  bit primed;

  force_t pending_forces[$];
  int errors;
  int send_idle, recv_idle;
  int hold_left;
  bit hold_req;
  longint cycles;

  haptic_spring_and_grip_force_core u_dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [9:0] spring_k(longint dx, longint dy, longint dz);
    longint d[3];
    longint unsigned m, sq, s, g, k2;
    int lo, hi, mid;
    d[0] = dx; d[1] = dy; d[2] = dz;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
      sq = m * m;
      if (s + sq < s) return 0;
      s = s + sq;
    end
    g = (longint'(gain_reg) * longint'(gain_reg)) << 48;
    lo = 0;
    hi = cap_reg;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k2 = longint'(mid) * longint'(mid);
      if (s <= g / k2) lo = mid;
      else hi = mid - 1;
    end
    return lo[9:0];
  endfunction

  function automatic force_t servo_tick(tick_t t);
    force_t r;
    longint d[3], ang, sg, diff, acc, y;
    longint unsigned mag;
    logic [9:0] k;
    d[0] = longint'(t.px) - longint'(anchor_x);
    d[1] = longint'(t.py) - longint'(anchor_y);
    d[2] = longint'(t.pz) - longint'(anchor_z);
    if ((t.phase == hsg_pkg::PHASE_GRASP_A || t.phase == hsg_pkg::PHASE_GRASP_B) &&
        t.task_code != hsg_pkg::HOLD_TASK)
      k = 0;
    else
      k = spring_k(d[0], d[1], d[2]);
    r.fx = sat32((-longint'(k) * d[0] + 128) >>> 8);
    r.fy = sat32((-longint'(k) * d[1] + 128) >>> 8);
    r.fz = sat32((-longint'(k) * d[2] + 128) >>> 8);
    r.k = k;
    ang = longint'(t.angle) - longint'(hsg_pkg::GRIP_OFFSET);
    mag = ((ang < 0) ? longint'(-ang) : longint'(ang)) * longint'({32'd0, scale_reg});
    mag = (mag >> 24) + ((mag >> 23) & 1);
    sg = (ang < 0) ? -longint'(mag) : longint'(mag);
    diff = sat32(longint'(t.grasp) - sg);
    if (!primed) begin
      for (int i = 0; i < 3; i++) begin
        grip_hist[i] = diff;
        filt_hist[i] = diff;
      end
      primed = 1;
    end
    acc = longint'(hsg_pkg::COEF_B0) * diff + longint'(hsg_pkg::COEF_B1) * grip_hist[0]
        + longint'(hsg_pkg::COEF_B1) * grip_hist[1]
        + longint'(hsg_pkg::COEF_B0) * grip_hist[2]
        + longint'(hsg_pkg::COEF_A1) * filt_hist[0]
        + longint'(hsg_pkg::COEF_A2) * filt_hist[1]
        + longint'(hsg_pkg::COEF_A3) * filt_hist[2];
    y = sat32((acc + (64'sd1 << 27)) >>> 28);
    grip_hist[2] = grip_hist[1]; grip_hist[1] = grip_hist[0]; grip_hist[0] = diff;
    filt_hist[2] = filt_hist[1]; filt_hist[1] = filt_hist[0]; filt_hist[0] = y;
    r.grip = (y > 0) ? 31'((y + 128) >>> 8) : 31'd0;
    return r;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      hsg_pkg::REG_BASE_X: anchor_x = value;
      hsg_pkg::REG_BASE_Y: anchor_y = value;
      hsg_pkg::REG_BASE_Z: anchor_z = value;
      hsg_pkg::REG_GAIN:   gain_reg = value[7:0];
      hsg_pkg::REG_CAP:    cap_reg = value[9:0];
      hsg_pkg::REG_SCALE:  scale_reg = value;
      default: ;
    endcase
  endtask

  task automatic send_tick(tick_t t);
    force_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    pos_x <= t.px; pos_y <= t.py; pos_z <= t.pz;
    grip_angle <= t.angle; slave_grasp <= t.grasp;
    grasp_phase <= t.phase; task_state <= t.task_code;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    r = servo_tick(t);
    if (t.known_k >= 0) r.k = t.known_k[9:0];
    pending_forces.push_back(r);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick32(logic [31:0] centre);
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4, 5: return centre + $urandom_range(0, 1 << 27) - (1 << 26);
      default: return $urandom;
    endcase
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.px = pick32(anchor_x);
    t.py = pick32(anchor_y);
    t.pz = pick32(anchor_z);
    t.angle = pick32(hsg_pkg::GRIP_OFFSET);
    t.grasp = pick32(32'h0);
    t.phase = $urandom_range(15);
    t.task_code = ($urandom_range(3) == 0) ? hsg_pkg::HOLD_TASK : 8'($urandom);
    t.known_k = -1;
    return t;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_tick(random_tick());
  endtask

  tick_t directed[] = '{
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 4'd0, 8'd0, 200},
    '{32'h7fffffff, 32'sd0, 32'sd0, 32'h7fffffff, 32'h80000000, 4'd0, 8'd0, 0},
    '{32'h80000000, 32'sd0, 32'sd0, 32'h80000000, 32'h7fffffff, 4'd0, 8'd0, 0},
    '{32'sd16777216, 32'sd0, 32'sd0, 32'sd878453, 32'sd0, 4'd1, 8'd0, 4},
    '{32'sd0, -32'sd16777216, 32'sd0, 32'sd0, 32'sd1000000, 4'd0, 8'd10, 4},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd5000000, 32'sd9000000, 4'd2, 8'd0, 0},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 4'd3, 8'd255, 0},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 4'd3, 8'd10, 200},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 4'd2, 8'd10, 200},
    '{32'sd100, 32'sd0, 32'sd0, -32'sd3000000, 32'sd40000000, 4'd15, 8'd9, -1},
    '{32'sd3000000, 32'sd4000000, -32'sd2000000, 32'sd878452, -32'sd100, 4'd4, 8'd11, -1},
    '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'sd0, 32'sd0, 4'd0, 8'd10, 0},
    '{32'h80000000, 32'h80000000, 32'h80000000, 32'sd0, 32'sd0, 4'd15, 8'd255, 0},
    '{32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1, 4'd0, 8'd0, 200}
  };

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 4000;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    force_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_forces.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = pending_forces.pop_front();
        if (force_x !== e.fx) begin
          $error("force_x exp %0d got %0d", e.fx, force_x); errors++;
        end
        if (force_y !== e.fy) begin
          $error("force_y exp %0d got %0d", e.fy, force_y); errors++;
        end
        if (force_z !== e.fz) begin
          $error("force_z exp %0d got %0d", e.fz, force_z); errors++;
        end
        if (grip_force !== e.grip) begin
          $error("grip_force exp %0d got %0d", e.grip, grip_force); errors++;
        end
        if (stiffness !== e.k) begin
          $error("stiffness exp %0d got %0d", e.k, stiffness); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    errors = 0; cycles = 0; hold_left = 0; hold_req = 0;
    send_idle = 7; recv_idle = 57;
    anchor_x = 0; anchor_y = 0; anchor_z = 0;
    gain_reg = 4; cap_reg = 200; scale_reg = 32'd16777216;
    primed = 0;
    for (int i = 0; i < 3; i++) begin
      grip_hist[i] = 0;
      filt_hist[i] = 0;
    end
    rst = 1; in_valid = 0; out_stall = 0;
    pos_x = 0; pos_y = 0; pos_z = 0; grip_angle = 0; slave_grasp = 0;
    grasp_phase = 0; task_state = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (directed[i]) send_tick(directed[i]);
    drain();

    reg_write(hsg_pkg::REG_BASE_X, $urandom_range(0, 1 << 26));
    reg_write(hsg_pkg::REG_BASE_Y, -$urandom_range(0, 1 << 26));
    reg_write(hsg_pkg::REG_BASE_Z, $urandom);
    reg_write(hsg_pkg::REG_GAIN, 8'd255);
    reg_write(hsg_pkg::REG_CAP, 10'd1023);
    reg_write(hsg_pkg::REG_SCALE, 32'd16777216);
    hold_req = 1;
    run_random(150);
    drain();

    send_idle = 57; recv_idle = 7;
    reg_write(hsg_pkg::REG_BASE_X, 32'h80000000);
    reg_write(hsg_pkg::REG_BASE_Y, 32'h80000000);
    reg_write(hsg_pkg::REG_BASE_Z, 32'h7fffffff);
    reg_write(hsg_pkg::REG_GAIN, 8'd0);
    reg_write(hsg_pkg::REG_CAP, 10'd0);
    reg_write(hsg_pkg::REG_SCALE, 32'hffffffff);
    reg_write(hsg_pkg::REG_SPARE_A, $urandom);
    reg_write(hsg_pkg::REG_SPARE_B, $urandom);
    run_random(75);
    drain();
    reg_write(hsg_pkg::REG_CAP, 10'd1023);
    run_random(75);
    drain();

    send_idle = 0; recv_idle = 0;
    reg_write(hsg_pkg::REG_BASE_X, $urandom);
    reg_write(hsg_pkg::REG_BASE_Y, $urandom);
    reg_write(hsg_pkg::REG_BASE_Z, $urandom);
    reg_write(hsg_pkg::REG_GAIN, $urandom_range(1, 255));
    reg_write(hsg_pkg::REG_CAP, $urandom_range(1, 1023));
    reg_write(hsg_pkg::REG_SCALE, $urandom);
    run_random(75);
    drain();
    reg_write(hsg_pkg::REG_BASE_X, 32'h7fffffff);
    reg_write(hsg_pkg::REG_BASE_Y, 32'h0);
    reg_write(hsg_pkg::REG_BASE_Z, 32'h80000000);
    reg_write(hsg_pkg::REG_GAIN, 8'd4);
    reg_write(hsg_pkg::REG_CAP, 10'd200);
    reg_write(hsg_pkg::REG_SCALE, $urandom_range(0, 1 << 26));
    run_random(75);
    drain();
    run_random(150);
    drain();

    repeat (3000) @(posedge clk);
    if (errors == 0 && pending_forces.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
